[src/uuidp_pkg.sv]
`default_nettype none

package uuidp_pkg;

  localparam logic [5:0] UUID_DIGITS = 6'd32;
  localparam logic [5:0] HALF_DIGITS = 6'd16;

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BRACE        = 3'd2,
    ST_LEAD_HYPHEN  = 3'd3,
    ST_DOUBLE_HYPHEN = 3'd4,
    ST_BAD_CHAR     = 3'd5,
    ST_FEW_DIGITS   = 3'd6,
    ST_EXTRA        = 3'd7
  } status_e;

  // per-string parse state
  typedef struct packed {
    logic [5:0]  digit_count;
    logic [63:0] high_accum;
    logic [63:0] low_accum;
    logic [5:0]  char_count;
    logic        has_braces;
    logic        at_string_start;
    logic        at_content_start;
    logic        prev_was_hyphen;
    status_e     first_error;
  } state_t;

  localparam state_t RESET_STATE = '{
    digit_count:      6'd0,
    high_accum:       64'd0,
    low_accum:        64'd0,
    char_count:       6'd0,
    has_braces:       1'b0,
    at_string_start:  1'b1,
    at_content_start: 1'b1,
    prev_was_hyphen:  1'b0,
    first_error:      ST_OK
  };

  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h.valid  = 1'b0;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid  = 1'b1;
      h.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low nibble 1..6
      h.valid  = 1'b1;
      h.nibble = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[src/uuid_text_parser.sv]
`default_nettype none

// UUID text parser. Feed the string one byte per request on char_in_i, with
// is_last_i set on the final byte; that byte yields exactly one result: the
// 128-bit value (value_high_o = first 16 hex digits, value_low_o = last 16)
// and status_o (0 ok, 1 short, 2 brace mismatch, 3 leading hyphen, 4 double
// hyphen, 5 bad char, 6 few digits, 7 extra content). Values read zero on
// any error. Throughput is one byte per cycle unless the input stalls:
// each byte goes through an input register, then a single step of
// digit/hyphen/brace logic updates the parse state and, on the last byte,
// loads the result register, which raises out_valid_o. The input side
// stalls only while a last byte sits in the input register and the result
// register still holds an untaken result; ordinary bytes keep flowing.
// Parser state returns to its reset values after every last byte.

module uuid_text_parser
  import uuidp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_high_o,
  output logic [63:0] value_low_o,
  output logic [2:0]  status_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;

  // parse state and result register
  state_t  state_q, state_d;
  result_t step_res;
  result_t res_q;
  logic    out_valid_q;

  logic out_free;
  logic advance;

  uuidp_step u_step (
    .char_i   (char_q),
    .last_i   (last_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // result register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // non-last bytes never need the result register
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= char_in_i;
      last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_STATE;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && last_q) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_high_o = res_q.value_high;
  assign value_low_o  = res_q.value_low;
  assign status_o     = res_q.status;

endmodule

`default_nettype wire

[src/uuidp_step.sv]
`default_nettype none

module uuidp_step
  import uuidp_pkg::*;
(
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  state_t     state_i,
  output state_t     state_o,
  output result_t    result_o
);

  always_comb begin
    state_t  st;
    logic    content;
    logic    first;
    hex_t    hx;
    status_e status;

    st      = state_i;
    content = 1'b1;
    first   = 1'b0;
    hx      = hex_value(char_i);

    if (st.char_count < UUID_DIGITS) begin
      st.char_count = st.char_count + 6'd1;
    end

    if (st.at_string_start) begin
      st.at_string_start = 1'b0;
      if (char_i == CH_OPEN) begin
        st.has_braces = 1'b1;
        content       = 1'b0;
      end
    end
    // closing byte of a braced string is not content
    if (content && last_i && st.has_braces) begin
      content = 1'b0;
    end

    if (content) begin
      first               = st.at_content_start;
      st.at_content_start = 1'b0;
      if (st.first_error == ST_OK) begin
        if (st.digit_count >= UUID_DIGITS) begin
          st.first_error = ST_EXTRA;
        end else if (char_i == CH_HYPHEN) begin
          if (first) begin
            st.first_error = ST_LEAD_HYPHEN;
          end else if (st.prev_was_hyphen) begin
            st.first_error = ST_DOUBLE_HYPHEN;
          end else begin
            st.prev_was_hyphen = 1'b1;
          end
        end else if (!hx.valid) begin
          st.first_error = ST_BAD_CHAR;
        end else begin
          if (st.digit_count < HALF_DIGITS) begin
            st.high_accum = {st.high_accum[59:0], hx.nibble};
          end else begin
            st.low_accum = {st.low_accum[59:0], hx.nibble};
          end
          st.digit_count     = st.digit_count + 6'd1;
          st.prev_was_hyphen = 1'b0;
        end
      end
    end

    if (st.char_count < UUID_DIGITS) begin
      status = ST_SHORT;
    end else if (st.has_braces && char_i != CH_CLOSE) begin
      status = ST_BRACE;
    end else if (st.first_error != ST_OK) begin
      status = st.first_error;
    end else if (st.digit_count < UUID_DIGITS) begin
      status = ST_FEW_DIGITS;
    end else begin
      status = ST_OK;
    end

    result_o.status     = status;
    result_o.value_high = (status == ST_OK) ? st.high_accum : 64'd0;
    result_o.value_low  = (status == ST_OK) ? st.low_accum : 64'd0;

    // a finished string leaves the parser ready for the next one
    state_o = last_i ? RESET_STATE : st;
  end

endmodule

`default_nettype wire

[src/uuidp_checker.sv]
`default_nettype none

module uuidp_checker
  import uuidp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        is_last_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] value_high_o,
  input wire logic [63:0] value_low_o,
  input wire logic [2:0]  status_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(value_high_o) && $stable(value_low_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // any error status carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> value_high_o == 64'd0 && value_low_o == 64'd0)
    else $error("nonzero value with error status");

  // a last byte that moves past the input register produces a result
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && is_last_i) ##1 !in_stall_o |=> out_valid_o)
    else $error("last byte gave no result");

endmodule

bind uuid_text_parser uuidp_checker u_uuidp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .is_last_i    (is_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_high_o (value_high_o),
  .value_low_o  (value_low_o),
  .status_o     (status_o)
);

`default_nettype wire
